// ----- hdl/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation unit.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package mexp_pkg;

  // Operand width of the exponentiation
  localparam int WORD_BITS = 32;
  // Bit counter width of the serial multiplier
  localparam int CNT_W = $clog2(WORD_BITS);

  // Operation run by the shared serial unit
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL,
    OP_SQR
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic go;
    op_t  op;
    logic shift;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mod_zero;
    logic y_zero;
    logic y_hi_zero;
    logic y_b0;
    logic y_b1;
    logic last;
  } stat_t;

endpackage

// ----- hdl/mexp_dp.sv -----
// Datapath: modulus register, operand registers and the bit-serial modular multiplier.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_dp import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic                 cfg_we,
  input  logic [WORD_BITS-1:0] cfg_data,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  output logic [WORD_BITS-1:0] power,
  output logic                 error
);

  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] y;
  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_W-1:0]     cnt;
  logic                 run;
  op_t                  op;
  logic                 err;

  logic [WORD_BITS-1:0] b_src;
  logic                 bbit;
  logic [WORD_BITS:0]   dbl;
  logic [WORD_BITS:0]   mod_ext;
  logic [WORD_BITS-1:0] red1;
  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS-1:0] acc_next;
  logic                 last;

  // Double the accumulator (shifting in a base bit when reducing), then add x when the multiplier bit is set
  always_comb begin
    mod_ext  = {1'b0, modulus};
    b_src    = (op == OP_MUL) ? r : x;
    bbit     = b_src[cnt];
    dbl      = {acc, (op == OP_REDUCE) ? bbit : 1'b0};
    red1     = (dbl >= mod_ext) ? WORD_BITS'(dbl - mod_ext) : dbl[WORD_BITS-1:0];
    sum      = {1'b0, red1} + (((op != OP_REDUCE) && bbit) ? {1'b0, x} : '0);
    acc_next = (sum >= mod_ext) ? WORD_BITS'(sum - mod_ext) : sum[WORD_BITS-1:0];
    last     = run && (cnt == '0);
  end

  // Status toward the controller
  always_comb begin
    stat.mod_zero  = (modulus == '0);
    stat.y_zero    = (y == '0);
    stat.y_hi_zero = (y[WORD_BITS-1:1] == '0);
    stat.y_b0      = y[0];
    stat.y_b1      = y[1];
    stat.last      = last;
  end

  // Control registers: modulus and the serial unit's run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WORD_BITS'(1);
      run     <= 1'b0;
    end else begin
      if (cfg_we) begin
        modulus <= cfg_data;
      end
      if (cmd.go) begin
        run <= 1'b1;
      end else if (last) begin
        run <= 1'b0;
      end
    end
  end

  // Serial unit: restart on go, else step one multiplier bit per cycle while run is set
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      acc <= '0;
      cnt <= CNT_W'(WORD_BITS - 1);
      op  <= cmd.op;
    end else if (run) begin
      acc <= acc_next;
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Operand registers: load a new transaction, write back finished results, shift the exponent
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= base;
      y   <= exponent;
      r   <= (modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
      err <= (modulus == '0);
    end else begin
      if (last) begin
        case (op)
          OP_MUL:  r <= acc_next;
          default: x <= acc_next;
        endcase
      end
      if (cmd.shift) begin
        y <= {1'b0, y[WORD_BITS-1:1]};
      end
    end
  end

  assign power = err ? '1 : r;
  assign error = err;

endmodule

// ----- hdl/mexp_ctrl.sv -----
// Controller: sequences base reduction, multiplies and squarings over the exponent bits.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_ctrl import mexp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_REDUCE;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.mod_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.go     = 1'b1;
            cmd.op     = OP_REDUCE;
            state_next = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (stat.last) begin
          if (stat.y_zero) begin
            state_next = S_DONE;
          end else if (stat.y_b0) begin
            cmd.go     = 1'b1;
            cmd.op     = OP_MUL;
            state_next = S_MUL;
          end else begin
            cmd.go     = 1'b1;
            cmd.op     = OP_SQR;
            state_next = S_SQR;
          end
        end
      end
      S_MUL: begin
        // skip the trailing squaring once no exponent bits remain
        if (stat.last) begin
          if (stat.y_hi_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.go     = 1'b1;
            cmd.op     = OP_SQR;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        // advance to the next exponent bit
        if (stat.last) begin
          cmd.shift = 1'b1;
          cmd.go    = 1'b1;
          if (stat.y_b1) begin
            cmd.op     = OP_MUL;
            state_next = S_MUL;
          end else begin
            cmd.op     = OP_SQR;
            state_next = S_SQR;
          end
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- hdl/modular_exponentiation_unit.sv -----
// On a zero modulus, done comes in the cycle after the accepting edge; otherwise the unit
// runs a base reduction and then squarings and multiplies, at most 32 multiplies and 31 squarings,
// each on the bit-serial modular multiplier shared by all steps.
// One transaction at a time; busy stays high through the done strobe and start is taken in the
// cycle after it, so a new request is only taken once the previous result has been given.
// Reset (rst, synchronous, active high) returns to idle and sets the modulus to 1.
// Top level: joins controller and datapath. Depends on mexp_pkg, mexp_ctrl, mexp_dp.
`timescale 1ns / 1ps

module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] base,
  input  logic [WORD_BITS-1:0] exponent,
  output logic                 done,
  output logic [WORD_BITS-1:0] power,
  output logic                 error,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WORD_BITS-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Take configuration transactions while idle
  assign cfg_ready = !busy;

  mexp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mexp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .base     (base),
    .exponent (exponent),
    .power    (power),
    .error    (error)
  );

endmodule

// ----- hdl/mexp_checker.sv -----
// Port-level checks for the modular exponentiation unit, bound to the top level.
// Depends on mexp_pkg.
`timescale 1ns / 1ps

module mexp_checker import mexp_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [WORD_BITS-1:0] power,
  input logic                 error
);

  // A result only follows an accepted or running transaction
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start || busy)) else $error("done without a transaction in progress");

  // Return to idle right after a result
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done)) else $error("not idle after done");

  // An accepted transaction raises busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised after start");

  // Error results carry all ones
  a_error_power: assert property (@(posedge clk) disable iff (rst)
    (done && error) |-> (power == '1)) else $error("error result not all ones");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .power (power),
  .error (error)
);

// ----- verif/tb_modular_exponentiation_unit.sv -----
// Self-checking testbench for modular_exponentiation_unit: drives base/exponent
// requests over several modulus settings and compares power/error against a predictor.
// Depends on mexp_pkg and the modular_exponentiation_unit RTL.
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;
  import mexp_pkg::*;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct {
    word_t power;
    logic  error;
  } power_result_t;

  // Predicts each result when a request is accepted and checks results in order
  class power_scoreboard;
    power_result_t expected_powers[$];
    int            requests_noted;
    int            results_checked;
    int            failures;

    function new();
      requests_noted  = 0;
      results_checked = 0;
      failures        = 0;
    endfunction

    // (a * b) mod m over the full double-width product
    function word_t mul_mod(word_t a, word_t b, word_t m);
      logic [2*WORD_BITS-1:0] prod;
      prod = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
      return word_t'(prod % {{WORD_BITS{1'b0}}, m});
    endfunction

    // Right-to-left square-and-multiply
    function power_result_t predict_power(word_t b, word_t e, word_t m);
      power_result_t res;
      word_t         x;
      word_t         r;
      if (m == '0) begin
        res.power = '1;
        res.error = 1'b1;
        return res;
      end
      x = b % m;
      r = word_t'(1) % m;
      for (int i = 0; i < WORD_BITS; i++) begin
        if (e[i])
          r = mul_mod(r, x, m);
        x = mul_mod(x, x, m);
      end
      res.power = r;
      res.error = 1'b0;
      return res;
    endfunction

    function void note_request(word_t b, word_t e, word_t m);
      expected_powers.insert(expected_powers.size(), predict_power(b, e, m));
      requests_noted++;
    endfunction

    function void check_power(word_t power, logic error);
      power_result_t exp_res;
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result power %h error %b", $time, power, error);
        failures++;
        return;
      end
      exp_res = expected_powers.pop_front();
      results_checked++;
      if (power !== exp_res.power) begin
        $display("%0t: power mismatch expected %h actual %h", $time, exp_res.power, power);
        failures++;
      end
      if (error !== exp_res.error) begin
        $display("%0t: error mismatch expected %b actual %b", $time, exp_res.error, error);
        failures++;
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  start;
  logic  busy;
  word_t base;
  word_t exponent;
  logic  done;
  word_t power;
  logic  error;
  logic  cfg_valid;
  logic  cfg_ready;
  word_t cfg_data;

  power_scoreboard sb = new();
  word_t           modulus_now = word_t'(1);
  int              modulus_settings = 1;

  modular_exponentiation_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .base      (base),
    .exponent  (exponent),
    .done      (done),
    .power     (power),
    .error     (error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note each accepted transaction with the modulus in force
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_request(base, exponent, modulus_now);
  end

  // Check each result strobe
  always @(posedge clk) begin
    if (!rst && done)
      sb.check_power(power, error);
  end

  // Drop start and hold until every outstanding result is back
  task wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the modulus register while the block is idle
  task set_modulus(input word_t value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= $urandom;
    modulus_now = value;
    modulus_settings++;
  endtask

  // Present one request and hold it until accepted; start is left high
  task send_request(input word_t b, input word_t e);
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  task idle_gap(input int cycles);
    start    <= 1'b0;
    base     <= $urandom;
    exponent <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task run_directed();
    // Reset modulus of one: every power is zero
    send_request(32'd5, 32'd3);
    send_request(32'd0, 32'd0);
    // Zero modulus: error with all-ones power
    set_modulus(32'd0);
    send_request(32'd7, 32'd9);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Largest modulus: base reduction, zero exponent, zero base
    set_modulus(32'hFFFF_FFFF);
    send_request(32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'd5);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(32'd2, 32'd31);
    send_request(32'd1, 32'hFFFF_FFFF);
    send_request(32'd0, 32'd5);
    send_request(32'h1234_5678, 32'h0000_0001);
    // Prime modulus: Fermat case returns one
    set_modulus(32'hFFFF_FFFB);
    send_request(32'd3, 32'hFFFF_FFFA);
    send_request(32'hFFFF_FFFF, 32'd2);
    send_request(32'h1234_5678, 32'h8000_0000);
    // Smallest nontrivial modulus
    set_modulus(32'd2);
    send_request(32'd3, 32'd0);
    send_request(32'd4, 32'd1);
    send_request(32'd5, 32'd7);
    // Top-bit modulus
    set_modulus(32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd3, 32'd40);
  endtask

  task run_random_phase(input word_t m, input int count, input bit with_gaps);
    word_t b;
    word_t e;
    set_modulus(m);
    for (int i = 0; i < count; i++) begin
      // Idle in bursts only on alternate stretches of ten
      if (with_gaps && ((i / 10) % 2 == 0) && $urandom_range(0, 2) == 0)
        idle_gap($urandom_range(1, 11));
      b = $urandom;
      e = $urandom;
      case ($urandom_range(0, 7))
        0: e = $urandom_range(0, 15);
        1: b = m - word_t'(1);
        2: b = $urandom_range(0, 3);
        3: e = e | 32'h8000_0000;
        default: ;
      endcase
      send_request(b, e);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    base      <= '0;
    exponent  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random_phase(32'hFFFF_FFFF, 40, 1'b1);
    run_random_phase($urandom, 40, 1'b1);
    run_random_phase(32'h8000_0000, 35, 1'b1);
    run_random_phase($urandom_range(2, 255), 35, 1'b1);
    run_random_phase(32'd0, 20, 1'b1);
    run_random_phase(32'hFFFF_FFFB, 35, 1'b1);
    run_random_phase(32'd1, 15, 1'b1);
    // Final stretch back to back
    run_random_phase($urandom | 32'h0001_0000, 40, 1'b0);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Covered %0d requests and %0d checked results over %0d modulus settings,",
             sb.requests_noted, sb.results_checked, modulus_settings);
    $display("including zero, one, two, top-bit and all-ones moduli and zero exponents.");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("modular_exponentiation_unit test passed");
    end else begin
      $display("modular_exponentiation_unit test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("modular_exponentiation_unit test failed");
    $finish;
  end

endmodule
